// File: hw/rtl/dpdc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the dual pid drive controller
// no dependencies

package dpdc_pkg;

  localparam int unsigned FieldW  = 24;
  localparam int unsigned DriveW  = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned ErrW  = FieldW + 1;
  localparam int unsigned DiffW = FieldW + 2;
  localparam int unsigned IntW  = 18;
  localparam int unsigned IrawW = IntW + 1;
  localparam int unsigned MulAW = DiffW;
  localparam int unsigned MulBW = CfgW + 1;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned LatW  = ProdW + 1;
  localparam int unsigned LoW   = 22;
  localparam int unsigned HiW   = LatW - LoW;
  localparam int unsigned ScW   = LatW + MulBW;
  localparam int unsigned QShift = 8;
  localparam int unsigned ScaledW = ScW - QShift;
  localparam int unsigned TurnW = ProdW + 2;
  localparam int unsigned SumW  = ScaledW + 1;

  localparam logic [CfgW-1:0] LatPReset   = 16'd26;
  localparam logic [CfgW-1:0] LatDReset   = 16'd26;
  localparam logic [CfgW-1:0] TurnPReset  = 16'd179;
  localparam logic [CfgW-1:0] TurnIReset  = 16'd26;
  localparam logic [CfgW-1:0] TurnDReset  = 16'd26;
  localparam logic [CfgW-1:0] IZoneReset  = 16'd3;
  localparam logic [CfgW-1:0] ILimitReset = 16'd300;
  localparam logic [CfgW-1:0] ScaleReset  = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LATERAL_P_GAIN  = 3'd0,
    REG_LATERAL_D_GAIN  = 3'd1,
    REG_TURN_P_GAIN     = 3'd2,
    REG_TURN_I_GAIN     = 3'd3,
    REG_TURN_D_GAIN     = 3'd4,
    REG_INTEGRAL_ZONE   = 3'd5,
    REG_INTEGRAL_LIMIT  = 3'd6,
    REG_DRIVE_SCALE     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [FieldW-1:0] left_position;
    logic signed [FieldW-1:0] right_position;
    logic signed [FieldW-1:0] heading;
    logic signed [FieldW-1:0] target_position;
    logic signed [FieldW-1:0] target_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
  } out_item_t;

endpackage

// File: hw/rtl/dual_pid_drive_controller.sv
`timescale 1ns / 1ps
// dual pid drive controller: lateral pd and turn pid with integral zone
// ERR, DIFF and MUL states, then ST_OUT registers the result once any old one is taken
// one item at a time, taken only in ST_IDLE; eight steps on one 26x17 multiplier
// reset: gains and limits take their defaults, error history and integral clear
// depends on dpdc_pkg

module dual_pid_drive_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dpdc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dpdc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dpdc_pkg::out_item_t           out_data_o
);
  import dpdc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_MUL,
    ST_OUT
  } state_e;

  function automatic logic signed [DriveW-1:0] sat16(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'(32767));
    lo = SumW'(signed'(-32768));
    if (x > hi) begin
      return DriveW'(hi);
    end else if (x < lo) begin
      return DriveW'(lo);
    end
    return x[DriveW-1:0];
  endfunction

  state_e state_q;
  logic [2:0] step_q;

  logic [CfgW-1:0] lat_p_q, lat_d_q, turn_p_q, turn_i_q, turn_d_q;
  logic [CfgW-1:0] izone_q, ilimit_q, scale_q;

  logic signed [ErrW-1:0]   last_e_q, last_t_q;
  logic signed [IntW-1:0]   integ_q;

  logic signed [ErrW-1:0]   sum_q, tpos_q, t_q, e_q;
  logic signed [DiffW-1:0]  de_q, dt_q;
  logic signed [IrawW-1:0]  iraw_q;
  logic signed [IntW-1:0]   inew_q;
  logic signed [ProdW-1:0]  p_q;
  logic signed [LatW-1:0]   lat_q;
  logic signed [ScW-1:0]    sc_q;
  logic signed [TurnW-1:0]  turn_q;

  logic      out_valid_q;
  out_item_t out_q;

  // error stage
  logic signed [ErrW-1:0]  half;
  logic signed [ErrW-1:0]  corr;
  logic signed [ErrW-1:0]  e_d;
  logic        [ErrW-1:0]  abs_t;
  logic                    in_zone;
  logic signed [IrawW-1:0] iraw_d;

  assign half    = sum_q >>> 1;
  assign corr    = ErrW'(signed'({1'b0, sum_q[ErrW-1] & sum_q[0]}));
  assign e_d     = tpos_q - half - corr;
  assign abs_t   = t_q[ErrW-1] ? ErrW'(-t_q) : ErrW'(t_q);
  assign in_zone = abs_t < {{(ErrW-CfgW){1'b0}}, izone_q};
  assign iraw_d  = in_zone ? (IrawW'(integ_q) + t_q[IrawW-1:0]) : '0;

  // integral clamp
  logic signed [IrawW-1:0] lim_pos, lim_neg;
  logic signed [IntW-1:0]  inew_d;

  assign lim_pos = signed'({{(IrawW-CfgW){1'b0}}, ilimit_q});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (iraw_q > lim_pos) begin
      inew_d = lim_pos[IntW-1:0];
    end else if (iraw_q < lim_neg) begin
      inew_d = lim_neg[IntW-1:0];
    end else begin
      inew_d = iraw_q[IntW-1:0];
    end
  end

  // shared multiplier operand select
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] p_d;

  always_comb begin
    case (step_q)
      3'd0: begin
        mul_a = MulAW'(e_q);
        mul_b = signed'({1'b0, lat_p_q});
      end
      3'd1: begin
        mul_a = de_q;
        mul_b = signed'({1'b0, lat_d_q});
      end
      3'd2: begin
        mul_a = MulAW'(t_q);
        mul_b = signed'({1'b0, turn_p_q});
      end
      3'd3: begin
        mul_a = signed'({{(MulAW-LoW){1'b0}}, lat_q[LoW-1:0]});
        mul_b = signed'({1'b0, scale_q});
      end
      3'd4: begin
        mul_a = dt_q;
        mul_b = signed'({1'b0, turn_d_q});
      end
      3'd5: begin
        mul_a = MulAW'(signed'(lat_q[LatW-1:LoW]));
        mul_b = signed'({1'b0, scale_q});
      end
      3'd6: begin
        mul_a = MulAW'(inew_q);
        mul_b = signed'({1'b0, turn_i_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_d = mul_a * mul_b;

  // output sums
  logic signed [SumW-1:0] scaled_x, turn_x;
  assign scaled_x = SumW'(signed'(sc_q[ScW-1:QShift]));
  assign turn_x   = SumW'(turn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_p_q  <= LatPReset;
      lat_d_q  <= LatDReset;
      turn_p_q <= TurnPReset;
      turn_i_q <= TurnIReset;
      turn_d_q <= TurnDReset;
      izone_q  <= IZoneReset;
      ilimit_q <= ILimitReset;
      scale_q  <= ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_LATERAL_P_GAIN: lat_p_q  <= cfg_data_i;
        REG_LATERAL_D_GAIN: lat_d_q  <= cfg_data_i;
        REG_TURN_P_GAIN:    turn_p_q <= cfg_data_i;
        REG_TURN_I_GAIN:    turn_i_q <= cfg_data_i;
        REG_TURN_D_GAIN:    turn_d_q <= cfg_data_i;
        REG_INTEGRAL_ZONE:  izone_q  <= cfg_data_i;
        REG_INTEGRAL_LIMIT: ilimit_q <= cfg_data_i;
        REG_DRIVE_SCALE:    scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      last_e_q    <= '0;
      last_t_q    <= '0;
      integ_q     <= '0;
      sum_q       <= '0;
      tpos_q      <= '0;
      t_q         <= '0;
      e_q         <= '0;
      de_q        <= '0;
      dt_q        <= '0;
      iraw_q      <= '0;
      inew_q      <= '0;
      p_q         <= '0;
      lat_q       <= '0;
      sc_q        <= '0;
      turn_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sum_q   <= ErrW'(in_data_i.left_position) + ErrW'(in_data_i.right_position);
            tpos_q  <= ErrW'(in_data_i.target_position);
            t_q     <= ErrW'(in_data_i.heading) - ErrW'(in_data_i.target_heading);
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          e_q     <= e_d;
          dt_q    <= DiffW'(t_q) - DiffW'(last_t_q);
          iraw_q  <= iraw_d;
          state_q <= ST_DIFF;
        end
        ST_DIFF: begin
          de_q    <= DiffW'(e_q) - DiffW'(last_e_q);
          inew_q  <= inew_d;
          step_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          p_q <= p_d;
          case (step_q)
            3'd1: lat_q  <= LatW'(p_q);
            3'd2: lat_q  <= lat_q + LatW'(p_q);
            3'd3: turn_q <= TurnW'(p_q);
            3'd4: sc_q   <= ScW'(p_q);
            3'd5: turn_q <= turn_q + TurnW'(p_q);
            3'd6: sc_q   <= sc_q + (ScW'(p_q) <<< LoW);
            3'd7: turn_q <= turn_q + TurnW'(p_q);
            default: ;
          endcase
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.left_drive  <= sat16(scaled_x - turn_x);
            out_q.right_drive <= sat16(scaled_x + turn_x);
            out_valid_q       <= 1'b1;
            last_e_q          <= e_q;
            last_t_q          <= t_q;
            integ_q           <= inew_q;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/dpdc_checker.sv
`timescale 1ns / 1ps
// port-level checks of the dual pid drive controller, bound to the top level
// depends on dpdc_pkg and dual_pid_drive_controller

module dpdc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input dpdc_pkg::out_item_t           out_data_o
);
  import dpdc_pkg::*;

  // busy for at least the error and difference steps after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while an item is in progress");

  // a new result only appears at the end of a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind dual_pid_drive_controller dpdc_checker u_dpdc_checker (.*);
